@@ rtl/psa_pkg.sv @@
// shared types, register codes and size constants for the mask scatter address generator
package psa_pkg;

    localparam int NB_W       = 9;
    localparam int FS_W       = 8;
    localparam int MS_W       = 8;
    localparam int HM_W       = 7;
    localparam int VALUE_W    = 32;
    localparam int BADDR_W    = 36;
    localparam int MADDR_W    = 38;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int DEF_MAX_FEATURE = 128;
    localparam int DEF_MAX_MASK    = 255;
    localparam int DEF_MAX_BATCH   = 256;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATCH_COUNT      = 3'd0,
        REG_FEATURE_HEIGHT   = 3'd1,
        REG_FEATURE_WIDTH    = 3'd2,
        REG_MASK_HEIGHT      = 3'd3,
        REG_MASK_WIDTH       = 3'd4,
        REG_HALF_MASK_HEIGHT = 3'd5,
        REG_HALF_MASK_WIDTH  = 3'd6,
        REG_LAYOUT_MODE      = 3'd7
    } t_reg_idx;

    // effective sizes after zero and saturation handling
    typedef struct packed {
        logic [NB_W-1:0] nb;
        logic [FS_W-1:0] fh;
        logic [FS_W-1:0] fw;
        logic [MS_W-1:0] mh;
        logic [MS_W-1:0] mw;
        logic [HM_W-1:0] hmh;
        logic [HM_W-1:0] hmw;
        logic            mode;
    } t_cfg;

    function automatic int cnt_w(input int maxv);
        return (maxv > 1) ? $clog2(maxv) : 1;
    endfunction

endpackage

@@ rtl/psa_cfg.sv @@
// configuration registers and effective size computation
module psa_cfg import psa_pkg::*; #(
    parameter int MAX_FEATURE = DEF_MAX_FEATURE,
    parameter int MAX_MASK    = DEF_MAX_MASK,
    parameter int MAX_BATCH   = DEF_MAX_BATCH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [NB_W-1:0] r_nb;
    logic [FS_W-1:0] r_fh;
    logic [FS_W-1:0] r_fw;
    logic [MS_W-1:0] r_mh;
    logic [MS_W-1:0] r_mw;
    logic [HM_W-1:0] r_hmh;
    logic [HM_W-1:0] r_hmw;
    logic            r_mode;

    function automatic logic [NB_W-1:0] sat(input logic [NB_W-1:0] v, input int maxv);
        logic [NB_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = NB_W'(1);
        end else if (int'(v) > maxv) begin
            res = NB_W'(maxv);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb   <= NB_W'(1);
            r_fh   <= FS_W'(1);
            r_fw   <= FS_W'(1);
            r_mh   <= MS_W'(1);
            r_mw   <= MS_W'(1);
            r_hmh  <= '0;
            r_hmw  <= '0;
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_BATCH_COUNT:      r_nb   <= i_cfg_data[NB_W-1:0];
                REG_FEATURE_HEIGHT:   r_fh   <= i_cfg_data[FS_W-1:0];
                REG_FEATURE_WIDTH:    r_fw   <= i_cfg_data[FS_W-1:0];
                REG_MASK_HEIGHT:      r_mh   <= i_cfg_data[MS_W-1:0];
                REG_MASK_WIDTH:       r_mw   <= i_cfg_data[MS_W-1:0];
                REG_HALF_MASK_HEIGHT: r_hmh  <= i_cfg_data[HM_W-1:0];
                REG_HALF_MASK_WIDTH:  r_hmw  <= i_cfg_data[HM_W-1:0];
                REG_LAYOUT_MODE:      r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.nb   = sat(r_nb, MAX_BATCH);
        o_cfg.fh   = FS_W'(sat(NB_W'(r_fh), MAX_FEATURE));
        o_cfg.fw   = FS_W'(sat(NB_W'(r_fw), MAX_FEATURE));
        o_cfg.mh   = MS_W'(sat(NB_W'(r_mh), MAX_MASK));
        o_cfg.mw   = MS_W'(sat(NB_W'(r_mw), MAX_MASK));
        o_cfg.hmh  = r_hmh;
        o_cfg.hmw  = r_hmw;
        o_cfg.mode = r_mode;
    end

endmodule

@@ rtl/psa_front.sv @@
// front end: position counters and feature map range check
module psa_front import psa_pkg::*; #(
    parameter int MAX_FEATURE = DEF_MAX_FEATURE,
    parameter int MAX_MASK    = DEF_MAX_MASK,
    parameter int MAX_BATCH   = DEF_MAX_BATCH,
    localparam int NCW = cnt_w(MAX_BATCH),
    localparam int MCW = cnt_w(MAX_MASK),
    localparam int FCW = cnt_w(MAX_FEATURE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_q_full,
    output logic               o_push,
    output logic [VALUE_W-1:0] o_value,
    output logic [NCW-1:0]     o_n,
    output logic [MCW-1:0]     o_mrow,
    output logic [MCW-1:0]     o_mcol,
    output logic [FCW-1:0]     o_h,
    output logic [FCW-1:0]     o_w,
    output logic [FS_W-1:0]    o_fr,
    output logic [FS_W-1:0]    o_fc
);

    localparam int MX1 = (NCW > MCW) ? NCW : MCW;
    localparam int MX2 = (MX1 > FCW) ? MX1 : FCW;
    localparam int SW  = ((MX2 > NB_W) ? MX2 : NB_W) + 1;
    localparam int MX3 = (MCW > FCW) ? MCW : FCW;
    localparam int DW  = ((MX3 > FS_W) ? MX3 : FS_W) + 2;

    logic [NCW-1:0] r_n,    n_n;
    logic [MCW-1:0] r_mrow, n_mrow;
    logic [MCW-1:0] r_mcol, n_mcol;
    logic [FCW-1:0] r_h,    n_h;
    logic [FCW-1:0] r_w,    n_w;

    logic          accept;
    logic          w_last, h_last, mc_last, mr_last, n_last;
    logic [DW-1:0] fr_s, fc_s;
    logic          in_map;

    assign accept = i_valid && !i_q_full;
    assign o_stall = i_q_full;

    // shifted position, negative values compare as huge
    assign fr_s   = DW'(r_mrow) + DW'(r_h) - DW'(i_cfg.hmh);
    assign fc_s   = DW'(r_mcol) + DW'(r_w) - DW'(i_cfg.hmw);
    assign in_map = (fr_s < DW'(i_cfg.fh)) && (fc_s < DW'(i_cfg.fw));

    assign o_push  = accept && in_map;
    assign o_value = i_value;
    assign o_n     = r_n;
    assign o_mrow  = r_mrow;
    assign o_mcol  = r_mcol;
    assign o_h     = r_h;
    assign o_w     = r_w;
    assign o_fr    = fr_s[FS_W-1:0];
    assign o_fc    = fc_s[FS_W-1:0];

    assign w_last  = !((SW'(r_w) + SW'(1)) < SW'(i_cfg.fw));
    assign h_last  = !((SW'(r_h) + SW'(1)) < SW'(i_cfg.fh));
    assign mc_last = !((SW'(r_mcol) + SW'(1)) < SW'(i_cfg.mw));
    assign mr_last = !((SW'(r_mrow) + SW'(1)) < SW'(i_cfg.mh));
    assign n_last  = !((SW'(r_n) + SW'(1)) < SW'(i_cfg.nb));

    always_comb begin
        n_w    = w_last ? '0 : r_w + FCW'(1);
        n_h    = r_h;
        n_mcol = r_mcol;
        n_mrow = r_mrow;
        n_n    = r_n;
        if (w_last) begin
            n_h = h_last ? '0 : r_h + FCW'(1);
            if (h_last) begin
                n_mcol = mc_last ? '0 : r_mcol + MCW'(1);
                if (mc_last) begin
                    n_mrow = mr_last ? '0 : r_mrow + MCW'(1);
                    if (mr_last) begin
                        n_n = n_last ? '0 : r_n + NCW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_mrow <= '0;
            r_mcol <= '0;
            r_h    <= '0;
            r_w    <= '0;
        end else if (accept) begin
            r_n    <= n_n;
            r_mrow <= n_mrow;
            r_mcol <= n_mcol;
            r_h    <= n_h;
            r_w    <= n_w;
        end
    end

endmodule

@@ rtl/psa_fifo.sv @@
// short request queue between front end and address pipeline
module psa_fifo import psa_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = cnt_w(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count lost a request");
`endif

endmodule

@@ rtl/psa_back.sv @@
// back end: pipelined buffer and mask address arithmetic with output register
module psa_back import psa_pkg::*; #(
    parameter int MAX_FEATURE = DEF_MAX_FEATURE,
    parameter int MAX_MASK    = DEF_MAX_MASK,
    parameter int MAX_BATCH   = DEF_MAX_BATCH,
    localparam int NCW = cnt_w(MAX_BATCH),
    localparam int MCW = cnt_w(MAX_MASK),
    localparam int FCW = cnt_w(MAX_FEATURE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [NCW-1:0]     i_n,
    input  logic [MCW-1:0]     i_mrow,
    input  logic [MCW-1:0]     i_mcol,
    input  logic [FCW-1:0]     i_h,
    input  logic [FCW-1:0]     i_w,
    input  logic [FS_W-1:0]    i_fr,
    input  logic [FS_W-1:0]    i_fc,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [VALUE_W-1:0] o_value_out,
    output logic [BADDR_W-1:0] o_buffer_address,
    output logic [MADDR_W-1:0] o_mask_address
);

    localparam int NSTG  = 7;
    localparam int AREAW = 2 * FS_W;
    localparam int MMW   = 2 * MS_W;
    localparam int QAW   = FCW + FS_W;
    localparam int QW    = QAW + 1;
    localparam int PW    = 2 * FS_W;
    localparam int RMW   = MCW + MS_W;
    localparam int RM2W  = RMW + 1;
    localparam int NAW   = NCW + AREAW;
    localparam int NMW   = NCW + MMW;
    localparam int SELW  = (QW > PW) ? QW : PW;
    localparam int TWF   = ((NAW > SELW) ? NAW : SELW) + 1;
    localparam int TW    = (TWF < BADDR_W) ? TWF : BADDR_W;
    localparam int MAF   = ((NMW > RM2W) ? NMW : RM2W) + 1;
    localparam int MA1W  = (MAF < MADDR_W) ? MAF : MADDR_W;
    localparam int BPW   = (TW + AREAW > BADDR_W) ? TW + AREAW : BADDR_W;
    localparam int MPW   = (MA1W + FS_W > MADDR_W) ? MA1W + FS_W : MADDR_W;
    localparam int M4W   = MADDR_W + FS_W;

    logic [NSTG-1:0] r_vld;
    logic            en;

    // stage 1
    logic [VALUE_W-1:0] r1_value;
    logic [NCW-1:0]     r1_n;
    logic [MCW-1:0]     r1_mcol;
    logic [FCW-1:0]     r1_h, r1_w;
    logic [FS_W-1:0]    r1_fc;
    logic [AREAW-1:0]   r1_area;
    logic [MMW-1:0]     r1_mm;
    logic [QAW-1:0]     r1_qa;
    logic [PW-1:0]      r1_pa;
    logic [RMW-1:0]     r1_rm;
    // stage 2
    logic [VALUE_W-1:0] r2_value;
    logic [FCW-1:0]     r2_h, r2_w;
    logic [AREAW-1:0]   r2_area;
    logic [NAW-1:0]     r2_na;
    logic [NMW-1:0]     r2_nm;
    logic [QW-1:0]      r2_q;
    logic [PW-1:0]      r2_p;
    logic [RM2W-1:0]    r2_rm;
    // stage 3
    logic [VALUE_W-1:0] r3_value;
    logic [FCW-1:0]     r3_h, r3_w;
    logic [AREAW-1:0]   r3_area;
    logic [TW-1:0]      r3_t;
    logic [SELW-1:0]    r3_o;
    logic [MA1W-1:0]    r3_ma1;
    // stage 4
    logic [VALUE_W-1:0] r4_value;
    logic [FCW-1:0]     r4_h, r4_w;
    logic [BADDR_W-1:0] r4_b;
    logic [SELW-1:0]    r4_o;
    logic [MADDR_W-1:0] r4_ma2;
    // stage 5
    logic [VALUE_W-1:0] r5_value;
    logic [FCW-1:0]     r5_w;
    logic [BADDR_W-1:0] r5_b;
    logic [MADDR_W-1:0] r5_ma3;
    // stage 6
    logic [VALUE_W-1:0] r6_value;
    logic [FCW-1:0]     r6_w;
    logic [BADDR_W-1:0] r6_b;
    logic [MADDR_W-1:0] r6_ma4;
    // output register
    logic [VALUE_W-1:0] r7_value;
    logic [BADDR_W-1:0] r7_b;
    logic [MADDR_W-1:0] r7_ma;

    logic [BPW-1:0]  b_prod;
    logic [MPW-1:0]  ma2_prod;
    logic [M4W-1:0]  ma4_prod;
    logic [SELW-1:0] q_ext, p_ext;

    assign en      = !r_vld[NSTG-1] || !i_stall;
    assign o_q_pop = en && i_q_valid;
    assign o_valid = r_vld[NSTG-1];

    assign q_ext    = SELW'(r2_q);
    assign p_ext    = SELW'(r2_p);
    assign b_prod   = BPW'(r3_t) * BPW'(r3_area);
    assign ma2_prod = MPW'(r3_ma1) * MPW'(i_cfg.fh);
    assign ma4_prod = M4W'(r5_ma3) * M4W'(i_cfg.fw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_q_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_value <= i_value;
            r1_n     <= i_n;
            r1_mcol  <= i_mcol;
            r1_h     <= i_h;
            r1_w     <= i_w;
            r1_fc    <= i_fc;
            r1_area  <= AREAW'(i_cfg.fh) * AREAW'(i_cfg.fw);
            r1_mm    <= MMW'(i_cfg.mh) * MMW'(i_cfg.mw);
            r1_qa    <= QAW'(i_h) * QAW'(i_cfg.fw);
            r1_pa    <= PW'(i_fr) * PW'(i_cfg.fw);
            r1_rm    <= RMW'(i_mrow) * RMW'(i_cfg.mw);

            r2_value <= r1_value;
            r2_h     <= r1_h;
            r2_w     <= r1_w;
            r2_area  <= r1_area;
            r2_na    <= NAW'(r1_n) * NAW'(r1_area);
            r2_nm    <= NMW'(r1_n) * NMW'(r1_mm);
            r2_q     <= QW'(r1_qa) + QW'(r1_w);
            r2_p     <= r1_pa + PW'(r1_fc);
            r2_rm    <= RM2W'(r1_rm) + RM2W'(r1_mcol);

            r3_value <= r2_value;
            r3_h     <= r2_h;
            r3_w     <= r2_w;
            r3_area  <= r2_area;
            r3_t     <= TW'(r2_na) + TW'(i_cfg.mode ? q_ext : p_ext);
            r3_o     <= i_cfg.mode ? p_ext : q_ext;
            r3_ma1   <= MA1W'(r2_nm) + MA1W'(r2_rm);

            r4_value <= r3_value;
            r4_h     <= r3_h;
            r4_w     <= r3_w;
            r4_b     <= b_prod[BADDR_W-1:0];
            r4_o     <= r3_o;
            r4_ma2   <= ma2_prod[MADDR_W-1:0];

            r5_value <= r4_value;
            r5_w     <= r4_w;
            r5_b     <= r4_b + BADDR_W'(r4_o);
            r5_ma3   <= r4_ma2 + MADDR_W'(r4_h);

            r6_value <= r5_value;
            r6_w     <= r5_w;
            r6_b     <= r5_b;
            r6_ma4   <= ma4_prod[MADDR_W-1:0];

            r7_value <= r6_value;
            r7_b     <= r6_b;
            r7_ma    <= r6_ma4 + MADDR_W'(r6_w);
        end
    end

    assign o_value_out      = r7_value;
    assign o_buffer_address = r7_b;
    assign o_mask_address   = r7_ma;

endmodule

@@ rtl/psa_mask_scatter_address_gen.sv @@
// Mask scatter address generator top level. Mask elements stream in with feature column
// fastest, then feature row, mask column, mask row and batch; the front end tracks that
// position, drops elements whose shifted position falls outside the feature map and queues
// the rest in a four-entry request queue. The back end is a seven-stage multiply/add pipeline
// that forms the buffer address (collect or distribute layout) and the mask address, ending
// in the output register. One element is taken per clock cycle while the output is not
// stalled; a stalled result freezes the pipeline, the queue fills up to four requests and
// then the input stalls, for elements outside the map as well. An accepted element is held
// in the queue and then passes the six pipeline stages ahead of the output register.
// Configuration writes take effect at once and keep the position counters; write them only
// while no request is in flight.
module psa_mask_scatter_address_gen import psa_pkg::*; #(
    parameter int MAX_FEATURE = DEF_MAX_FEATURE,
    parameter int MAX_MASK    = DEF_MAX_MASK,
    parameter int MAX_BATCH   = DEF_MAX_BATCH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_W-1:0]    i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_W-1:0]    o_value_out,
    output logic [BADDR_W-1:0]    o_buffer_address,
    output logic [MADDR_W-1:0]    o_mask_address
);

    localparam int NCW = cnt_w(MAX_BATCH);
    localparam int MCW = cnt_w(MAX_MASK);
    localparam int FCW = cnt_w(MAX_FEATURE);
    localparam int EW  = VALUE_W + NCW + 2 * MCW + 2 * FCW + 2 * FS_W;

    t_cfg cfg;

    logic               q_push, q_full, q_pop, q_valid;
    logic [EW-1:0]      q_wdata, q_rdata;

    logic [VALUE_W-1:0] f_value, b_value;
    logic [NCW-1:0]     f_n, b_n;
    logic [MCW-1:0]     f_mrow, b_mrow, f_mcol, b_mcol;
    logic [FCW-1:0]     f_h, b_h, f_w, b_w;
    logic [FS_W-1:0]    f_fr, b_fr, f_fc, b_fc;

    psa_cfg #(
        .MAX_FEATURE (MAX_FEATURE),
        .MAX_MASK    (MAX_MASK),
        .MAX_BATCH   (MAX_BATCH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    psa_front #(
        .MAX_FEATURE (MAX_FEATURE),
        .MAX_MASK    (MAX_MASK),
        .MAX_BATCH   (MAX_BATCH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_value  (f_value),
        .o_n      (f_n),
        .o_mrow   (f_mrow),
        .o_mcol   (f_mcol),
        .o_h      (f_h),
        .o_w      (f_w),
        .o_fr     (f_fr),
        .o_fc     (f_fc)
    );

    assign q_wdata = {f_value, f_n, f_mrow, f_mcol, f_h, f_w, f_fr, f_fc};

    psa_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {b_value, b_n, b_mrow, b_mcol, b_h, b_w, b_fr, b_fc} = q_rdata;

    psa_back #(
        .MAX_FEATURE (MAX_FEATURE),
        .MAX_MASK    (MAX_MASK),
        .MAX_BATCH   (MAX_BATCH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_q_valid        (q_valid),
        .o_q_pop          (q_pop),
        .i_value          (b_value),
        .i_n              (b_n),
        .i_mrow           (b_mrow),
        .i_mcol           (b_mcol),
        .i_h              (b_h),
        .i_w              (b_w),
        .i_fr             (b_fr),
        .i_fc             (b_fc),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value_out      (o_value_out),
        .o_buffer_address (o_buffer_address),
        .o_mask_address   (o_mask_address)
    );

endmodule

@@ dv/tb_psa_mask_scatter_address_gen.sv @@
// testbench for the mask scatter address generator with a predictor and result checker
module tb_psa_mask_scatter_address_gen;
    import psa_pkg::*;

    localparam int PIPE_LATENCY  = 7;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PCT      = 20;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BADDR_W-1:0] baddr;
        logic [MADDR_W-1:0] maddr;
    } t_mask_hit;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_stall;
    logic [VALUE_W-1:0]    req_value;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [VALUE_W-1:0]    rsp_value;
    logic [BADDR_W-1:0]    rsp_baddr;
    logic [MADDR_W-1:0]    rsp_maddr;

    // predictor copy of the registers and position counters
    logic [NB_W-1:0] nb_reg;
    logic [FS_W-1:0] fh_reg, fw_reg;
    logic [MS_W-1:0] mh_reg, mw_reg;
    logic [HM_W-1:0] hmh_reg, hmw_reg;
    logic            mode_reg;
    int unsigned     pos_n, pos_mr, pos_mc, pos_h, pos_w;

    t_mask_hit hit_q[$];
    int        mismatch_count;
    int        idle_cycles;
    int        hold_cycles;
    bit        tx_idle_en;
    bit        rx_idle_en;

    psa_mask_scatter_address_gen dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_valid          (req_valid),
        .o_stall          (req_stall),
        .i_value          (req_value),
        .o_valid          (rsp_valid),
        .i_stall          (rsp_stall),
        .o_value_out      (rsp_value),
        .o_buffer_address (rsp_baddr),
        .o_mask_address   (rsp_maddr)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_u64 eff_size(input t_u64 v, input t_u64 maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    task automatic predict_mask_elem(input logic [VALUE_W-1:0] v);
        t_u64      nb, fh, fw, mh, mw, area, p, q, baddr, maddr;
        longint    fr, fc;
        t_mask_hit hit;
        nb = eff_size(nb_reg, DEF_MAX_BATCH);
        fh = eff_size(fh_reg, DEF_MAX_FEATURE);
        fw = eff_size(fw_reg, DEF_MAX_FEATURE);
        mh = eff_size(mh_reg, DEF_MAX_MASK);
        mw = eff_size(mw_reg, DEF_MAX_MASK);
        fr = longint'(pos_mr) + longint'(pos_h) - longint'(hmh_reg);
        fc = longint'(pos_mc) + longint'(pos_w) - longint'(hmw_reg);
        if (fr >= 0 && fr < longint'(fh) && fc >= 0 && fc < longint'(fw)) begin
            area  = fh * fw;
            p     = t_u64'(fr) * fw + t_u64'(fc);
            q     = t_u64'(pos_h) * fw + t_u64'(pos_w);
            baddr = mode_reg ? (t_u64'(pos_n) * area + q) * area + p
                             : (t_u64'(pos_n) * area + p) * area + q;
            maddr = ((t_u64'(pos_n) * mh * mw + t_u64'(pos_mr) * mw + t_u64'(pos_mc)) * fh
                     + t_u64'(pos_h)) * fw + t_u64'(pos_w);
            hit.value = v;
            hit.baddr = baddr[BADDR_W-1:0];
            hit.maddr = maddr[MADDR_W-1:0];
            hit_q.push_back(hit);
        end
        // counters at or above a new limit wrap on their next advance
        if (t_u64'(pos_w) + 1 < fw) begin
            pos_w++;
        end else begin
            pos_w = 0;
            if (t_u64'(pos_h) + 1 < fh) begin
                pos_h++;
            end else begin
                pos_h = 0;
                if (t_u64'(pos_mc) + 1 < mw) begin
                    pos_mc++;
                end else begin
                    pos_mc = 0;
                    if (t_u64'(pos_mr) + 1 < mh) begin
                        pos_mr++;
                    end else begin
                        pos_mr = 0;
                        if (t_u64'(pos_n) + 1 < nb) pos_n++;
                        else pos_n = 0;
                    end
                end
            end
        end
    endtask

    task automatic send_mask_elem(input logic [VALUE_W-1:0] v);
        @(negedge clk);
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_value <= v;
        do @(posedge clk); while (req_stall);
        predict_mask_elem(v);
    endtask

    task automatic end_burst();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (hit_q.size() != 0) @(posedge clk);
    endtask

    task automatic settle_block();
        end_burst();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_BATCH_COUNT:      nb_reg   = data[NB_W-1:0];
            REG_FEATURE_HEIGHT:   fh_reg   = data[FS_W-1:0];
            REG_FEATURE_WIDTH:    fw_reg   = data[FS_W-1:0];
            REG_MASK_HEIGHT:      mh_reg   = data[MS_W-1:0];
            REG_MASK_WIDTH:       mw_reg   = data[MS_W-1:0];
            REG_HALF_MASK_HEIGHT: hmh_reg  = data[HM_W-1:0];
            REG_HALF_MASK_WIDTH:  hmw_reg  = data[HM_W-1:0];
            REG_LAYOUT_MODE:      mode_reg = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] nb, fh, fw, mh, mw, hmh, hmw,
                                input logic [CFG_DATA_W-1:0] mode);
        settle_block();
        write_reg(REG_BATCH_COUNT, nb);
        write_reg(REG_FEATURE_HEIGHT, fh);
        write_reg(REG_FEATURE_WIDTH, fw);
        write_reg(REG_MASK_HEIGHT, mh);
        write_reg(REG_MASK_WIDTH, mw);
        write_reg(REG_HALF_MASK_HEIGHT, hmh);
        write_reg(REG_HALF_MASK_WIDTH, hmw);
        write_reg(REG_LAYOUT_MODE, mode);
    endtask

    task automatic test_reset_defaults();
        send_mask_elem(32'h0000_0000);
        send_mask_elem(32'hFFFF_FFFF);
        send_mask_elem(32'h5555_5555);
        send_mask_elem(32'hAAAA_AAAA);
    endtask

    task automatic test_zero_sizes();
        apply_config(0, 0, 0, 0, 0, 0, 0, 1);
        send_mask_elem($urandom);
        send_mask_elem($urandom);
    endtask

    task automatic test_saturated_sizes();
        apply_config(9'h1FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 0, 0, 0);
        repeat (3) send_mask_elem($urandom);
    endtask

    // window partly off the map, counters left over from the wide map
    task automatic test_window_edges();
        apply_config(1, 2, 2, 2, 2, 1, 1, 1);
        repeat (16) send_mask_elem($urandom);
    endtask

    task automatic test_pause_for_drain();
        apply_config(2, 3, 2, 3, 2, 1, 0, 0);
        repeat (15) send_mask_elem($urandom);
        end_burst();
        wait_drained();
        repeat (15) send_mask_elem($urandom);
    endtask

    task automatic test_backpressure();
        apply_config(1, 2, 2, 1, 1, 0, 0, 0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        @(posedge clk);
        hold_cycles = 60;
        repeat (40) send_mask_elem($urandom);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // sizes of one so only the batch counter moves, past its saturated limit
    task automatic test_batch_wrap();
        apply_config(9'h1FF, 1, 1, 1, 1, 0, 0, 1);
        repeat (260) send_mask_elem($urandom);
    endtask

    task automatic test_random_configs(input int phases, input int per_phase, input bit idle);
        logic [CFG_DATA_W-1:0] nb, fh, fw, mh, mw, hmh, hmw, mode;
        for (int ph = 0; ph < phases; ph++) begin
            case ($urandom_range(0, 9))
                0:       nb = 0;
                1:       nb = $urandom_range(256, 511);
                default: nb = $urandom_range(1, 3);
            endcase
            case ($urandom_range(0, 9))
                0:       fh = 0;
                1:       fh = $urandom_range(128, 511);
                default: fh = $urandom_range(1, 5);
            endcase
            case ($urandom_range(0, 9))
                0:       fw = 0;
                1:       fw = $urandom_range(0, 511);
                default: fw = $urandom_range(1, 5);
            endcase
            case ($urandom_range(0, 9))
                0:       mh = 0;
                1:       mh = 9'h0FF;
                2:       mh = $urandom_range(0, 511);
                default: mh = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       mw = 0;
                1:       mw = 9'h1FF;
                default: mw = $urandom_range(1, 6);
            endcase
            hmh  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 3);
            hmw  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 3);
            mode = $urandom_range(0, 511);
            apply_config(nb, fh, fw, mh, mw, hmh, hmw, mode);
            tx_idle_en = idle;
            rx_idle_en = idle;
            repeat (per_phase) send_mask_elem($urandom);
            tx_idle_en = 1'b1;
            rx_idle_en = 1'b1;
        end
    endtask

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
        end else if (rx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            rsp_stall <= 1'b1;
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : result_check
        t_mask_hit exp_hit;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (hit_q.size() == 0) begin
                $display("%0t: unexpected result value_out %h buffer_address %h mask_address %h",
                         $time, rsp_value, rsp_baddr, rsp_maddr);
                mismatch_count++;
            end else begin
                exp_hit = hit_q.pop_front();
                if (rsp_value !== exp_hit.value) begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, exp_hit.value, rsp_value);
                    mismatch_count++;
                end
                if (rsp_baddr !== exp_hit.baddr) begin
                    $display("%0t: buffer_address expected %h actual %h",
                             $time, exp_hit.baddr, rsp_baddr);
                    mismatch_count++;
                end
                if (rsp_maddr !== exp_hit.maddr) begin
                    $display("%0t: mask_address expected %h actual %h",
                             $time, exp_hit.maddr, rsp_maddr);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req_valid      = 1'b0;
        req_value      = '0;
        rsp_stall      = 1'b0;
        nb_reg         = 1;
        fh_reg         = 1;
        fw_reg         = 1;
        mh_reg         = 1;
        mw_reg         = 1;
        hmh_reg        = 0;
        hmw_reg        = 0;
        mode_reg       = 1'b0;
        pos_n          = 0;
        pos_mr         = 0;
        pos_mc         = 0;
        pos_h          = 0;
        pos_w          = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        hold_cycles    = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_sizes();
        test_saturated_sizes();
        test_window_edges();
        test_pause_for_drain();
        test_backpressure();
        test_random_configs(5, 20, 1'b1);
        test_random_configs(1, 80, 1'b0);
        test_batch_wrap();
        test_random_configs(2, 40, 1'b1);

        settle_block();
        if (mismatch_count == 0 && hit_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
